// ----- src/sbb_pkg.sv -----
package sbb_pkg;

   localparam int MAX_WIDTH  = 256;
   localparam int MAX_HEIGHT = 256;
   localparam int MAX_RADIUS = 15;

   localparam logic FUNC_WRITE = 1'b0;
   localparam logic FUNC_READ  = 1'b1;

   localparam logic [1:0] CSR_WIDTH  = 2'd0;
   localparam logic [1:0] CSR_HEIGHT = 2'd1;
   localparam logic [1:0] CSR_RADIUS = 2'd2;
   localparam logic [1:0] CSR_SPARE  = 2'd3;

   localparam int PIX_W = 32;
   localparam int CH_W  = 8;
   localparam int CSR_DATA_W = 9;

   typedef struct packed {
      logic       func;
      logic [7:0] col;
      logic [7:0] row;
      logic [31:0] pixel_in;
   } req_type;

   typedef struct packed {
      logic [31:0] blurred_pixel;
   } rsp_type;

   typedef struct packed {
      logic        start;
      logic [12:0] dividend;
      logic [4:0]  divisor;
   } div_req_type;

endpackage

// ----- src/sbb_if.sv -----
interface sbb_if #(parameter type T = logic) ();
   logic valid;
   logic ready;
   T     payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// ----- src/sbb_div.sv -----
module sbb_div (
   input  logic                clock,
   input  logic                reset,
   input  sbb_pkg::div_req_type req,
   output logic                done,
   output logic [7:0]          quotient
);
   logic [12:0] rem_ff, rem_in;
   logic [7:0]  quo_ff, quo_in;
   logic [4:0]  den_ff, den_in;
   logic [3:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic [13:0] trial;

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      trial   = {1'b0, rem_ff} - ({9'd0, den_ff} << cnt_ff[2:0]);
      if (req.start) begin
         rem_in  = req.dividend;
         den_in  = req.divisor;
         quo_in  = '0;
         cnt_in  = 4'd7;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!trial[13]) begin
            rem_in = trial[12:0];
            quo_in[cnt_ff[2:0]] = 1'b1;
         end
         if (cnt_ff == 4'd0) busy_in = 1'b0;
         cnt_in = cnt_ff - 4'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

   assign done     = busy_ff && cnt_ff == 4'd0;
   assign quotient = quo_in;
endmodule

// ----- src/separable_box_blur_top.sv -----
// channel | dir | handshake   | payload
// req     | in  | valid/ready | func, col, row, pixel_in
// rsp     | out | valid/ready | blurred_pixel
// csr     | in  | csr_we      | csr_index, csr_data
// A write is stored as it is accepted. A read walks each window row: per column a read
// and an add, then four divides per row, then four more for the column average.
// A read outside the frame and a read at radius 0 skip the walk.
// Reset is synchronous; the frame memory is not cleared. A waiting rsp holds the next
// finished read in ST_OUT; no new request, write or read, is taken meanwhile.
module separable_box_blur_top (
   input  logic clock,
   input  logic reset,
   sbb_if.sink   req,
   sbb_if.source rsp,
   input  logic       csr_we,
   input  logic [1:0] csr_index,
   input  logic [8:0] csr_data
);
   localparam logic [3:0] ST_IDLE = 4'd0, ST_RD = 4'd1, ST_RDW = 4'd2, ST_HDIV = 4'd3,
      ST_HWAIT = 4'd4, ST_VDIV = 4'd5, ST_VWAIT = 4'd6, ST_OUT = 4'd7, ST_R0 = 4'd8;

   logic [8:0] w_ff, h_ff;
   logic [3:0] r_ff;
   logic [3:0] st_ff, st_in;
   logic [7:0] xi_ff, yi_ff, xlo_ff, xhi_ff, ylo_ff, yhi_ff;
   logic [7:0] xi_in, yi_in;
   logic [12:0] hs_ff [4], hs_in [4];
   logic [12:0] vs_ff [4], vs_in [4];
   logic [4:0]  hc_ff, vc_ff;
   logic [1:0]  k_ff, k_in;
   logic [31:0] rd_ff, res_ff, res_in, out_ff;
   logic        rv_ff;
   logic        out_go;
   logic [31:0] mem [sbb_pkg::MAX_WIDTH*sbb_pkg::MAX_HEIGHT];
   logic [15:0] raddr;
   logic        ren;
   sbb_pkg::div_req_type dreq;
   logic        ddone;
   logic [7:0]  dq;
   logic [8:0]  wc, hc, rc;
   logic [8:0]  xlo, xhi, ylo, yhi;

   always_ff @(posedge clock) begin
      if (reset) begin
         w_ff <= 9'd256; h_ff <= 9'd256; r_ff <= 4'd8;
      end else if (csr_we) begin
         unique case (csr_index)
            sbb_pkg::CSR_WIDTH:  w_ff <= csr_data;
            sbb_pkg::CSR_HEIGHT: h_ff <= csr_data;
            sbb_pkg::CSR_RADIUS: r_ff <= csr_data[3:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      wc = (w_ff == 9'd0) ? 9'd1 :
           (w_ff > 9'(sbb_pkg::MAX_WIDTH) ? 9'(sbb_pkg::MAX_WIDTH) : w_ff);
      hc = (h_ff == 9'd0) ? 9'd1 :
           (h_ff > 9'(sbb_pkg::MAX_HEIGHT) ? 9'(sbb_pkg::MAX_HEIGHT) : h_ff);
      rc = ({5'd0, r_ff} > 9'(sbb_pkg::MAX_RADIUS)) ? 9'(sbb_pkg::MAX_RADIUS) : {5'd0, r_ff};
      xlo = ({1'b0, req.payload.col} > rc) ? {1'b0, req.payload.col} - rc : 9'd0;
      xhi = ({1'b0, req.payload.col} + rc < wc - 9'd1) ? {1'b0, req.payload.col} + rc
            : wc - 9'd1;
      ylo = ({1'b0, req.payload.row} > rc) ? {1'b0, req.payload.row} - rc : 9'd0;
      yhi = ({1'b0, req.payload.row} + rc < hc - 9'd1) ? {1'b0, req.payload.row} + rc
            : hc - 9'd1;
   end

   assign req.ready = (st_ff == ST_IDLE);
   wire acc = req.valid && req.ready;
   assign out_go = (st_ff == ST_OUT) && (!rv_ff || rsp.ready);

   // memory port
   always_comb begin
      ren   = 1'b0;
      raddr = {yi_ff, xi_ff};
      if (st_ff == ST_RD) ren = 1'b1;
      if (acc) raddr = {req.payload.row, req.payload.col};
   end
   always_ff @(posedge clock) begin
      if (acc && req.payload.func == sbb_pkg::FUNC_WRITE &&
          {1'b0, req.payload.col} < 9'(sbb_pkg::MAX_WIDTH) &&
          {1'b0, req.payload.row} < 9'(sbb_pkg::MAX_HEIGHT))
         mem[{req.payload.row, req.payload.col}] <= req.payload.pixel_in;
      if (ren || acc) rd_ff <= mem[raddr];
   end

   always_comb begin
      st_in = st_ff; xi_in = xi_ff; yi_in = yi_ff; k_in = k_ff; res_in = res_ff;
      hs_in = hs_ff; vs_in = vs_ff;
      dreq = '0;
      unique case (st_ff)
         ST_IDLE: if (acc && req.payload.func == sbb_pkg::FUNC_READ) begin
            if ({1'b0, req.payload.col} >= wc || {1'b0, req.payload.row} >= hc) begin
               res_in = '0; st_in = ST_OUT;
            end else if (rc == 9'd0) st_in = ST_R0;
            else begin
               xi_in = xlo[7:0]; yi_in = ylo[7:0]; st_in = ST_RD;
               for (int k = 0; k < 4; k++) begin hs_in[k] = '0; vs_in[k] = '0; end
            end
         end
         ST_R0: begin res_in = rd_ff; st_in = ST_OUT; end
         ST_RD: st_in = ST_RDW;
         ST_RDW: begin
            for (int k = 0; k < 4; k++)
               hs_in[k] = hs_ff[k] + {5'd0, rd_ff[8*k +: 8]};
            if (xi_ff == xhi_ff) begin
               xi_in = xlo_ff; k_in = 2'd0; st_in = ST_HDIV;
            end else begin
               xi_in = xi_ff + 8'd1; st_in = ST_RD;
            end
         end
         ST_HDIV: begin
            dreq.start = 1'b1; dreq.dividend = hs_ff[k_ff]; dreq.divisor = hc_ff;
            st_in = ST_HWAIT;
         end
         ST_HWAIT: if (ddone) begin
            vs_in[k_ff] = vs_ff[k_ff] + {5'd0, dq};
            hs_in[k_ff] = '0;
            k_in = k_ff + 2'd1;
            if (k_ff != 2'd3) st_in = ST_HDIV;
            else if (yi_ff == yhi_ff) st_in = ST_VDIV;
            else begin yi_in = yi_ff + 8'd1; st_in = ST_RD; end
         end
         ST_VDIV: begin
            dreq.start = 1'b1; dreq.dividend = vs_ff[k_ff]; dreq.divisor = vc_ff;
            st_in = ST_VWAIT;
         end
         ST_VWAIT: if (ddone) begin
            res_in[8*k_ff +: 8] = dq;
            k_in = k_ff + 2'd1;
            st_in = (k_ff == 2'd3) ? ST_OUT : ST_VDIV;
         end
         ST_OUT: if (out_go) st_in = ST_IDLE;
         default: st_in = ST_IDLE;
      endcase
   end

   sbb_div u_div (.clock(clock), .reset(reset), .req(dreq), .done(ddone), .quotient(dq));

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_IDLE; rv_ff <= 1'b0; k_ff <= '0;
      end else begin
         st_ff <= st_in; k_ff <= k_in;
         if (out_go) rv_ff <= 1'b1;
         else if (rsp.ready) rv_ff <= 1'b0;
      end
      if (out_go) out_ff <= res_ff;
      xi_ff <= xi_in; yi_ff <= yi_in; res_ff <= res_in;
      hs_ff <= hs_in; vs_ff <= vs_in;
      if (acc) begin
         xlo_ff <= xlo[7:0]; xhi_ff <= xhi[7:0]; ylo_ff <= ylo[7:0]; yhi_ff <= yhi[7:0];
         hc_ff <= 5'(xhi - xlo + 9'd1); vc_ff <= 5'(yhi - ylo + 9'd1);
      end
   end

   assign rsp.valid = rv_ff;
   assign rsp.payload.blurred_pixel = out_ff;

   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req.ready |-> st_ff == ST_IDLE) else $error("ready while busy");
   a_out_valid: assert property (@(posedge clock) disable iff (reset)
      out_go |=> rsp.valid) else $error("result lost");
   a_no_acc_busy: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ready |=> rsp.valid) else $error("result dropped");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ready |=> $stable(rsp.payload)) else $error("result changed");
endmodule
